// ----- design/mwcf_pkg.sv -----
package mwcf_pkg;

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int THR_W       = 5;
    localparam int ROW_W       = 13;
    localparam int OUT_ROW_W   = 12;
    localparam int OUT_COL_W   = 11;
    localparam int PIXEL_W     = 8;
    localparam int RESULT_CAP  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_LIMIT     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic [THR_W-1:0]      FG_LIMIT_RESET     = 5'd5;

    localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;
    localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;

    typedef struct packed {
        logic [PIXEL_W-1:0] mask_value;
        logic               keep;
        logic               filler;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]   out_value;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 frame_done;
        logic                 last_in_run;
    } out_item_t;

endpackage

// ----- design/mwcf_ram.sv -----
module mwcf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/masked_window_count_filter_core.sv -----
// Binary mask cleanup filter. Mask pixels enter in raster order on the input
// channel (in_valid / in_stall / in_data), one request per pixel. A pixel is
// foreground when its value is nonzero and its keep bit is set. Each result on
// the output channel (out_valid / out_stall / out_data) is 255 when more than
// the foreground limit of pixels in the square window around it are set, else 0.
// Results trail the input by WINDOW_RADIUS rows and columns; the last pixel of
// a row releases up to three results. After a frame, WINDOW_RADIUS rows of
// filler requests drain the final rows.
// cfg_ready is always high. The user writes frame size and foreground limit on
// the cfg channel only while the block is idle; the block does not enforce it.
// A pixel's first result passes stages 1 and 2 and the output register to
// out_valid. One pixel is accepted per cycle unless the input stalls; a pixel
// with n results stalls the input while its first n - 1 go out, as the output
// carries one result a cycle. The line memory is read and rewritten once per
// pixel, one column word holding all buffered rows. When out_stall is high the
// result register holds and the input stalls once the two internal stages are
// full. Reset clears the counters, window and channel state; the line memory
// is not cleared and needs no clearing pass.
module masked_window_count_filter_core #(
    parameter int WINDOW_RADIUS = 2,
    parameter int MAX_WIDTH     = 2048
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  mwcf_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output mwcf_pkg::out_item_t                    out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mwcf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mwcf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int DIAM     = 2 * WINDOW_RADIUS + 1;
    localparam int LROWS    = 2 * WINDOW_RADIUS;
    localparam int WIN_BITS = DIAM * DIAM;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WID_W    = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W   = $clog2(LROWS);
    localparam int CNT_W    = $clog2(WIN_BITS + 1);
    localparam int JW       = $clog2(WINDOW_RADIUS + 1);
    localparam int ROW_W    = mwcf_pkg::ROW_W;

    // Configuration registers
    logic [mwcf_pkg::CFG_DATA_W-1:0] frame_width_reg;
    logic [mwcf_pkg::CFG_DATA_W-1:0] frame_height_reg;
    logic [mwcf_pkg::THR_W-1:0]      fg_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= mwcf_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= mwcf_pkg::FRAME_HEIGHT_RESET;
            fg_limit_reg     <= mwcf_pkg::FG_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mwcf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                mwcf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                mwcf_pkg::REG_FG_LIMIT:
                    fg_limit_reg <= cfg_data[mwcf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Input side: position counters and per-pixel decisions
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [WID_W-1:0]                w_eff;
    logic [mwcf_pkg::CFG_DATA_W-1:0] h_eff;
    logic                            in_fire;
    logic                            last_col;
    logic                            frame_end;
    logic                            fg;
    logic [ROW_W-1:0]                row_inc;

    assign in_fire = in_valid && !in_stall;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? mwcf_pkg::CFG_DATA_W'(1) : frame_height_reg;
    end

    assign last_col  = (WID_W'(col_reg) + WID_W'(1)) >= w_eff;
    assign frame_end = last_col &&
        ((15'(row_reg) + 15'd1) >= (15'(h_eff) + 15'(WINDOW_RADIUS)));
    assign fg = !in_data.filler && (row_reg < ROW_W'(h_eff)) &&
        (in_data.mask_value != '0) && in_data.keep;
    assign row_inc = row_reg + ROW_W'(1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (frame_end || row_inc == '0)
                begin
                    row_next  = frame_end ? '0 : row_inc;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_inc;
                    slot_next = (slot_reg == SLOT_W'(LROWS - 1)) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Stage 1: line memory read returns, column of the window is formed
    logic              s1_valid_reg;
    logic              s1_fg_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_last_col_reg;
    logic              s1_frame_end_reg;
    logic              s1_fwd_reg;
    logic [LROWS-1:0]  s1_fwd_word_reg;
    logic              s1_adv;

    logic [LROWS-1:0]  ram_rd_data;
    logic [LROWS-1:0]  word_cur;
    logic [LROWS-1:0]  word_new;
    logic [DIAM-1:0]   col_bits;
    logic [SLOT_W:0]   slot_sum;

    mwcf_ram #(
        .WIDTH (LROWS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (word_new),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // A write to the same column in the cycle of the read is forwarded.
    assign word_cur = s1_fwd_reg ? s1_fwd_word_reg : ram_rd_data;

    always_comb
    begin
        slot_sum = '0;
        col_bits = '0;
        word_new = word_cur;
        word_new[s1_slot_reg] = s1_fg_reg;
        for (int k = 1; k <= LROWS; k++)
        begin
            slot_sum = (SLOT_W + 1)'(s1_slot_reg) + (SLOT_W + 1)'(LROWS - k);
            if (slot_sum >= (SLOT_W + 1)'(LROWS))
            begin
                slot_sum = slot_sum - (SLOT_W + 1)'(LROWS);
            end
            col_bits[LROWS - k] = (s1_row_reg >= ROW_W'(k)) &&
                word_cur[slot_sum[SLOT_W-1:0]];
        end
        col_bits[LROWS] = s1_fg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= s1_adv && (s1_col_reg == col_reg);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_fg_reg        <= fg;
            s1_col_reg       <= col_reg;
            s1_row_reg       <= row_reg;
            s1_slot_reg      <= slot_reg;
            s1_last_col_reg  <= last_col;
            s1_frame_end_reg <= frame_end;
            s1_fwd_word_reg  <= word_new;
        end
    end

    // Window shift register, cleared at the start of each row
    logic [WIN_BITS-1:0] window_reg, window_next;
    logic [WIN_BITS-1:0] window_base;

    always_comb
    begin
        window_base = (s1_col_reg == '0) ? '0 : window_reg;
        window_next = window_reg;
        if (s1_adv)
        begin
            for (int dr = 0; dr < DIAM; dr++)
            begin
                window_next[dr * DIAM +: DIAM] =
                    {col_bits[dr], window_base[dr * DIAM + 1 +: DIAM - 1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    // Which results this pixel releases
    logic [JW-1:0] j_first;
    logic [JW-1:0] j_extra;
    logic [JW+1:0] j_limit;
    logic [JW-1:0] j_last;
    logic          has_results;

    always_comb
    begin
        j_first = (s1_col_reg >= COL_W'(WINDOW_RADIUS)) ? '0 :
            JW'(WINDOW_RADIUS) - JW'(s1_col_reg);
        j_extra = s1_last_col_reg ? JW'(WINDOW_RADIUS) : '0;
        j_limit = (JW + 2)'(j_first) + (JW + 2)'(mwcf_pkg::RESULT_CAP - 1);
        j_last  = (j_limit < (JW + 2)'(j_extra)) ? j_limit[JW-1:0] : j_extra;
        has_results = (s1_row_reg >= ROW_W'(WINDOW_RADIUS)) && (j_first <= j_extra);
    end

    // Stage 2: pending run of results, one handed to the output per cycle unless out_stall holds it
    logic                           pend_valid_reg;
    logic [WIN_BITS-1:0]            pend_win_reg;
    logic [mwcf_pkg::OUT_ROW_W-1:0] pend_row_reg;
    logic [COL_W-1:0]               pend_col_reg;
    logic [JW-1:0]                  pend_j_reg;
    logic [JW-1:0]                  pend_j_last_reg;
    logic                           pend_frame_end_reg;

    logic out_valid_reg;
    logic out_free;
    logic emit;
    logic pend_done;
    logic s2_load_ok;

    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = pend_valid_reg && out_free;
    assign pend_done  = emit && (pend_j_reg == pend_j_last_reg);
    assign s2_load_ok = !pend_valid_reg || pend_done;
    assign s1_adv     = s1_valid_reg && s2_load_ok;
    assign in_stall   = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (s1_adv && has_results)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_done)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && has_results)
        begin
            pend_win_reg       <= window_next;
            pend_row_reg       <= mwcf_pkg::OUT_ROW_W'(s1_row_reg - ROW_W'(WINDOW_RADIUS));
            pend_col_reg       <= s1_col_reg;
            pend_j_reg         <= j_first;
            pend_j_last_reg    <= j_last;
            pend_frame_end_reg <= s1_frame_end_reg;
        end
        else if (emit)
        begin
            pend_j_reg <= pend_j_reg + JW'(1);
        end
    end

    // Count of the window shifted left by j empty columns
    logic [DIAM-1:0]     row_shifted;
    logic [CNT_W-1:0]    win_count;
    logic [COL_W+1:0]    col_sum;
    mwcf_pkg::out_item_t result;

    always_comb
    begin
        win_count   = '0;
        row_shifted = '0;
        for (int dr = 0; dr < DIAM; dr++)
        begin
            row_shifted = pend_win_reg[dr * DIAM +: DIAM] >> pend_j_reg;
            for (int b = 0; b < DIAM; b++)
            begin
                win_count = win_count + CNT_W'(row_shifted[b]);
            end
        end
        col_sum = (COL_W + 2)'(pend_col_reg) + (COL_W + 2)'(pend_j_reg) -
            (COL_W + 2)'(WINDOW_RADIUS);
        result.out_value   = (32'(win_count) > 32'(fg_limit_reg)) ?
            mwcf_pkg::PIXEL_ON : mwcf_pkg::PIXEL_OFF;
        result.out_row     = pend_row_reg;
        result.out_col     = mwcf_pkg::OUT_COL_W'(col_sum);
        result.last_in_run = (pend_j_reg == pend_j_last_reg);
        result.frame_done  = (pend_j_reg == pend_j_last_reg) && pend_frame_end_reg;
    end

    // Output register
    mwcf_pkg::out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
